// ===== rtl/ibm_pkg.sv =====
// Package for the 16-bit ALU: opcodes, error codes and beat structs.
// No dependencies.
`timescale 1ns / 1ps
package ibm_pkg;
    localparam int WORD_BITS_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NEG_OVF = 2'd1,
        ERR_DIV_ZERO = 2'd2,
        ERR_DIV_OVF = 2'd3
    } err_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] operand_a;
        logic signed [15:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               overflow_flag;
        logic [1:0]         error_code;
    } rsp_t;
endpackage

// ===== rtl/ibm_div_stage.sv =====
// One pipelined step of the restoring divider on magnitudes.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module ibm_div_stage #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] div_in,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] div_out
);
    logic [W:0]   trial;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        trial = {rem_in, quo_in[W-1]} - {1'b0, div_in};
        if (trial[W])
        begin
            rem_next = {rem_in[W-2:0], quo_in[W-1]};
            quo_next = {quo_in[W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[W-1:0];
            quo_next = {quo_in[W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_out <= rem_next;
        quo_out <= quo_next;
        div_out <= div_in;
    end
endmodule

// ===== rtl/int16_booth_mul_signed_div_alu.sv =====
// One beat accepted every cycle.
// The product is formed as a beat enters and is carried beside the divider stages,
// which run one quotient bit per stage.
// Results cannot be stalled, so busy is always low.
// Reset clears only the valid pipeline; data registers take no reset.
`timescale 1ns / 1ps
module int16_booth_mul_signed_div_alu #(
    parameter int WORD_BITS = ibm_pkg::WORD_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ibm_pkg::req_t req,
    output logic          done,
    output ibm_pkg::rsp_t rsp
);
    import ibm_pkg::*;
    localparam int W = WORD_BITS;
    localparam int D = W + 1;

    logic [W-1:0] a, b, ma, mb, nb, sum_w;
    logic         sa, sb;
    rsp_t         fast;
    logic [2*W-1:0] prod;
    logic [31:0]  prod32;

    assign busy = 1'b0;
    assign a = W'(req.operand_a);
    assign b = W'(req.operand_b);
    assign sa = a[W-1];
    assign sb = b[W-1];
    assign ma = sa ? W'(-a) : a;
    assign mb = sb ? W'(-b) : b;
    assign nb = W'(-b);

    always_comb
    begin
        fast = '0;
        sum_w = '0;
        case (op_t'(req.req_type))
            OP_ADD:
            begin
                sum_w = a + b;
                fast.overflow_flag = (sa == sb) && (sum_w[W-1] != sa);
            end
            OP_SUB:
            begin
                if (b == {1'b1, {(W-1){1'b0}}})
                    fast.error_code = ERR_NEG_OVF;
                else
                begin
                    sum_w = a + nb;
                    fast.overflow_flag = (sa == nb[W-1]) && (sum_w[W-1] != sa);
                end
            end
            OP_DIV:
            begin
                if (b == '0)
                    fast.error_code = ERR_DIV_ZERO;
                else if (a == {1'b1, {(W-1){1'b0}}} && b == '1)
                    fast.error_code = ERR_DIV_OVF;
            end
            default: ;
        endcase
        fast.result_value = 32'(signed'({{32{sum_w[W-1]}}, sum_w}));
    end

    // Side channel carried alongside the divider stages.
    logic [D-1:0]  vld_reg;
    logic [1:0]    op_reg   [D];
    rsp_t          fast_reg [D];
    logic          neg_reg  [D];
    logic [W-1:0]  rem [W+1];
    logic [W-1:0]  quo [W+1];
    logic [W-1:0]  dvs [W+1];
    logic [W-1:0]  rem0_reg, quo0_reg, dvs0_reg;

    assign prod = ma * mb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[D-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        op_reg[0]   <= req.req_type;
        fast_reg[0] <= fast;
        neg_reg[0]  <= sa ^ sb;
        rem0_reg    <= '0;
        quo0_reg    <= ma;
        dvs0_reg    <= mb;
        for (int i = 1; i < D; i++)
        begin
            op_reg[i]   <= op_reg[i-1];
            fast_reg[i] <= fast_reg[i-1];
            neg_reg[i]  <= neg_reg[i-1];
        end
    end

    assign rem[0] = rem0_reg;
    assign quo[0] = quo0_reg;
    assign dvs[0] = dvs0_reg;

    for (genvar g = 0; g < W; g++)
    begin : g_div
        ibm_div_stage #(.W(W)) u_stage (
            .clk(clk), .rem_in(rem[g]), .quo_in(quo[g]), .div_in(dvs[g]),
            .rem_out(rem[g+1]), .quo_out(quo[g+1]), .div_out(dvs[g+1])
        );
    end

    // The product moves in step with the side channel until the beat reaches the end.
    logic [2*W-1:0] prod_line [D];
    always_ff @(posedge clk)
    begin
        prod_line[0] <= prod;
        for (int i = 1; i < D; i++)
            prod_line[i] <= prod_line[i-1];
    end

    logic [W-1:0] q_w;
    logic [2*W-1:0] p_s;
    always_comb
    begin
        rsp = fast_reg[D-1];
        q_w = neg_reg[D-1] ? W'(-quo[W]) : quo[W];
        p_s = neg_reg[D-1] ? (2*W)'(-prod_line[D-1]) : prod_line[D-1];
        prod32 = 32'(signed'(p_s));
        case (op_t'(op_reg[D-1]))
            OP_MUL: rsp.result_value = prod32;
            OP_DIV:
                if (rsp.error_code == ERR_OK)
                    rsp.result_value = 32'(signed'({{32{q_w[W-1]}}, q_w}));
            default: ;
        endcase
    end

    assign done = vld_reg[D-1];
endmodule

// ===== rtl/ibm_checker.sv =====
// Port-level checks for the ALU; bound to the top level below.
// Depends on ibm_pkg.
`timescale 1ns / 1ps
module ibm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ibm_pkg::rsp_t rsp
);
    import ibm_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##17 done) else $error("result beat missing");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 17)) else $error("unexpected result beat");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.error_code != ERR_OK |-> rsp.result_value == 0 && !rsp.overflow_flag)
        else $error("error beat carries data");
endmodule

bind int16_booth_mul_signed_div_alu ibm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
